// File: src/psl_pkg.sv
package psl_pkg;

	// Pool geometry
	localparam int NORMAL_SLOTS = 32;
	localparam int SUPER_SLOTS  = 8;
	localparam int TOTAL_SLOTS  = NORMAL_SLOTS + SUPER_SLOTS;

	// Field widths
	localparam int SLOT_W = 6;
	localparam int TYPE_W = 8;
	localparam int HND_W  = 16;

	localparam logic [SLOT_W-1:0] SUPER_FIRST = SLOT_W'(NORMAL_SLOTS);
	localparam logic [SLOT_W-1:0] HEAD_SLOT   = SLOT_W'(TOTAL_SLOTS);
	localparam logic [SLOT_W-1:0] END_MARK    = SLOT_W'(TOTAL_SLOTS + 1);

	typedef enum logic [1:0] {
		MODE_ALLOC_NORMAL,
		MODE_ALLOC_SUPER,
		MODE_KILL,
		MODE_KILL_ALL
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_EMPTY,
		STAT_INACTIVE
	} status_t;

	typedef struct packed {
		mode_t             mode;
		logic [SLOT_W-1:0] current_slot;
		logic [SLOT_W-1:0] target_slot;
		logic [TYPE_W-1:0] proc_type;
		logic [HND_W-1:0]  handler;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		status_t           status;
		logic [SLOT_W-1:0] killed_count;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_A_WALK,
		ST_A_RD_S,
		ST_A_RD_C,
		ST_A_WR_S,
		ST_A_WR_C,
		ST_K_WALK,
		ST_K_LINK,
		ST_K_REL,
		ST_KA_NEXT,
		ST_KA_EVAL,
		ST_KA_REL,
		ST_FINISH
	} state_t;

	// Link memory read address select
	typedef enum logic [2:0] {
		RD_HEAD,
		RD_LINK,
		RD_FREE,
		RD_CUR,
		RD_TGT,
		RD_P,
		RD_Q
	} rd_sel_t;

	// Link memory write operation
	typedef enum logic [2:0] {
		WR_NONE,
		WR_P_LINK,
		WR_CUR_P,
		WR_REL_TGT,
		WR_REL_Q
	} wr_op_t;

	// Walk pointer update
	typedef enum logic [2:0] {
		P_HOLD,
		P_HEAD,
		P_LINK,
		P_FREE,
		P_Q
	} p_op_t;

	typedef struct packed {
		logic    capture;
		rd_sel_t rd_sel;
		wr_op_t  wr_op;
		logic    info_wr;
		p_op_t   p_op;
		logic    q_load;
		logic    fh_pop;
		logic    stat_set;
		status_t stat_code;
		logic    slot_from_p;
		logic    cnt_inc;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		mode_t             mode;
		logic              fh_empty;
		logic              cur_is_head;
		logic              tgt_bad;
		logic              link_end;
		logic              link_is_cur;
		logic              link_is_tgt;
		logic              q_spared;
		logic [SLOT_W-1:0] normal_head;
		logic [SLOT_W-1:0] super_head;
	} sts_t;

	// Link value of an entry that has not been written since reset
	function automatic logic [SLOT_W-1:0] init_link(input logic [SLOT_W-1:0] a);
		logic [SLOT_W-1:0] r;
		if (a == SLOT_W'(NORMAL_SLOTS - 1) || a >= SLOT_W'(TOTAL_SLOTS - 1)) begin
			r = END_MARK;
		end else begin
			r = a + SLOT_W'(1);
		end
		return r;
	endfunction

endpackage

// File: src/psl_ctrl.sv
module psl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  psl_pkg::sts_t sts,
	output psl_pkg::cmd_t cmd
);

	psl_pkg::state_t state_q;
	psl_pkg::state_t state_nx;
	logic            rsp_valid_q;
	logic            out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == psl_pkg::ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= psl_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			psl_pkg::ST_IDLE: begin
				if (req_valid) state_nx = psl_pkg::ST_DECODE;
			end
			psl_pkg::ST_DECODE: begin
				case (sts.mode)
					psl_pkg::MODE_ALLOC_NORMAL, psl_pkg::MODE_ALLOC_SUPER: begin
						if (sts.fh_empty) state_nx = psl_pkg::ST_FINISH;
						else if (sts.cur_is_head) state_nx = psl_pkg::ST_A_RD_S;
						else state_nx = psl_pkg::ST_A_WALK;
					end
					psl_pkg::MODE_KILL: begin
						if (sts.tgt_bad) state_nx = psl_pkg::ST_FINISH;
						else state_nx = psl_pkg::ST_K_WALK;
					end
					default: state_nx = psl_pkg::ST_KA_NEXT;
				endcase
			end
			psl_pkg::ST_A_WALK: begin
				if (sts.link_end) state_nx = psl_pkg::ST_FINISH;
				else if (sts.link_is_cur) state_nx = psl_pkg::ST_A_RD_S;
			end
			psl_pkg::ST_A_RD_S: state_nx = psl_pkg::ST_A_RD_C;
			psl_pkg::ST_A_RD_C: state_nx = psl_pkg::ST_A_WR_S;
			psl_pkg::ST_A_WR_S: state_nx = psl_pkg::ST_A_WR_C;
			psl_pkg::ST_A_WR_C: state_nx = psl_pkg::ST_FINISH;
			psl_pkg::ST_K_WALK: begin
				if (sts.link_end) state_nx = psl_pkg::ST_FINISH;
				else if (sts.link_is_tgt) state_nx = psl_pkg::ST_K_LINK;
			end
			psl_pkg::ST_K_LINK: state_nx = psl_pkg::ST_K_REL;
			psl_pkg::ST_K_REL:  state_nx = psl_pkg::ST_FINISH;
			psl_pkg::ST_KA_NEXT: begin
				if (sts.link_end) state_nx = psl_pkg::ST_FINISH;
				else state_nx = psl_pkg::ST_KA_EVAL;
			end
			psl_pkg::ST_KA_EVAL: begin
				if (sts.q_spared) state_nx = psl_pkg::ST_KA_NEXT;
				else state_nx = psl_pkg::ST_KA_REL;
			end
			psl_pkg::ST_KA_REL: state_nx = psl_pkg::ST_KA_NEXT;
			psl_pkg::ST_FINISH: begin
				if (out_free) state_nx = psl_pkg::ST_IDLE;
			end
			default: state_nx = psl_pkg::ST_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd.capture     = 1'b0;
		cmd.rd_sel      = psl_pkg::RD_HEAD;
		cmd.wr_op       = psl_pkg::WR_NONE;
		cmd.info_wr     = 1'b0;
		cmd.p_op        = psl_pkg::P_HOLD;
		cmd.q_load      = 1'b0;
		cmd.fh_pop      = 1'b0;
		cmd.stat_set    = 1'b0;
		cmd.stat_code   = psl_pkg::STAT_OK;
		cmd.slot_from_p = 1'b0;
		cmd.cnt_inc     = 1'b0;
		cmd.out_load    = 1'b0;
		case (state_q)
			psl_pkg::ST_IDLE: begin
				cmd.capture = req_valid;
			end
			psl_pkg::ST_DECODE: begin
				cmd.p_op = psl_pkg::P_HEAD;
				case (sts.mode)
					psl_pkg::MODE_ALLOC_NORMAL, psl_pkg::MODE_ALLOC_SUPER: begin
						if (sts.fh_empty) begin
							cmd.stat_set  = 1'b1;
							cmd.stat_code = psl_pkg::STAT_EMPTY;
						end
					end
					psl_pkg::MODE_KILL: begin
						if (sts.tgt_bad) begin
							cmd.stat_set  = 1'b1;
							cmd.stat_code = psl_pkg::STAT_INACTIVE;
						end
					end
					default: ;
				endcase
			end
			psl_pkg::ST_A_WALK: begin
				if (sts.link_end) begin
					cmd.stat_set  = 1'b1;
					cmd.stat_code = psl_pkg::STAT_INACTIVE;
				end else if (!sts.link_is_cur) begin
					cmd.rd_sel = psl_pkg::RD_LINK;
				end
			end
			psl_pkg::ST_A_RD_S: begin
				cmd.rd_sel = psl_pkg::RD_FREE;
				cmd.p_op   = psl_pkg::P_FREE;
			end
			psl_pkg::ST_A_RD_C: begin
				cmd.fh_pop = 1'b1;
				cmd.rd_sel = psl_pkg::RD_CUR;
			end
			psl_pkg::ST_A_WR_S: begin
				cmd.wr_op   = psl_pkg::WR_P_LINK;
				cmd.info_wr = 1'b1;
			end
			psl_pkg::ST_A_WR_C: begin
				cmd.wr_op       = psl_pkg::WR_CUR_P;
				cmd.slot_from_p = 1'b1;
			end
			psl_pkg::ST_K_WALK: begin
				if (sts.link_end) begin
					cmd.stat_set  = 1'b1;
					cmd.stat_code = psl_pkg::STAT_INACTIVE;
				end else if (sts.link_is_tgt) begin
					cmd.rd_sel = psl_pkg::RD_TGT;
				end else begin
					cmd.rd_sel = psl_pkg::RD_LINK;
					cmd.p_op   = psl_pkg::P_LINK;
				end
			end
			psl_pkg::ST_K_LINK: begin
				cmd.wr_op = psl_pkg::WR_P_LINK;
			end
			psl_pkg::ST_K_REL: begin
				cmd.wr_op       = psl_pkg::WR_REL_TGT;
				cmd.slot_from_p = 1'b1;
				cmd.cnt_inc     = 1'b1;
			end
			psl_pkg::ST_KA_NEXT: begin
				if (!sts.link_end) begin
					cmd.q_load = 1'b1;
					cmd.rd_sel = psl_pkg::RD_LINK;
				end
			end
			psl_pkg::ST_KA_EVAL: begin
				if (sts.q_spared) begin
					cmd.p_op   = psl_pkg::P_Q;
					cmd.rd_sel = psl_pkg::RD_Q;
				end else begin
					cmd.wr_op = psl_pkg::WR_P_LINK;
				end
			end
			psl_pkg::ST_KA_REL: begin
				cmd.wr_op   = psl_pkg::WR_REL_Q;
				cmd.cnt_inc = 1'b1;
				cmd.rd_sel  = psl_pkg::RD_P;
			end
			psl_pkg::ST_FINISH: begin
				cmd.out_load = out_free;
			end
			default: ;
		endcase
	end

endmodule

// File: src/psl_dpath.sv
module psl_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  psl_pkg::req_t               req,
	input  logic                        cfg_we,
	input  logic [psl_pkg::TYPE_W-1:0]  cfg_data,
	input  psl_pkg::cmd_t               cmd,
	output psl_pkg::sts_t               sts,
	output psl_pkg::rsp_t               rsp
);

	localparam int SW = psl_pkg::SLOT_W;

	// Link memory: slots plus head sentinel, with a valid bit per entry so
	// unwritten entries read as their reset chain value.
	logic [SW-1:0]              link_mem [0:psl_pkg::TOTAL_SLOTS];
	logic [psl_pkg::TOTAL_SLOTS:0] link_vld_q;
	logic [psl_pkg::TYPE_W-1:0] type_mem [0:psl_pkg::TOTAL_SLOTS-1];
	logic [psl_pkg::HND_W-1:0]  hnd_mem  [0:psl_pkg::TOTAL_SLOTS-1];

	logic [SW-1:0]              link_raw_q;
	logic                       link_rvld_q;
	logic [SW-1:0]              rd_addr_q;
	logic [psl_pkg::TYPE_W-1:0] type_rd_q;

	psl_pkg::req_t              item_q;
	logic [psl_pkg::TYPE_W-1:0] prot_type_q;
	logic [SW-1:0]              nfh_q;
	logic [SW-1:0]              sfh_q;
	logic [SW-1:0]              p_q;
	logic [SW-1:0]              q_q;
	logic [SW-1:0]              res_slot_q;
	psl_pkg::status_t           res_status_q;
	logic [SW-1:0]              cnt_q;
	psl_pkg::rsp_t              rsp_q;

	logic [SW-1:0] rd_link;
	logic [SW-1:0] rd_addr;
	logic [SW-1:0] fh_sel;
	logic          sel_super;
	logic          wr_en;
	logic [SW-1:0] wr_addr;
	logic [SW-1:0] wr_data;
	logic          rel_en;
	logic [SW-1:0] rel_slot;

	assign rd_link   = link_rvld_q ? link_raw_q : psl_pkg::init_link(rd_addr_q);
	assign sel_super = (item_q.mode == psl_pkg::MODE_ALLOC_SUPER);
	assign fh_sel    = sel_super ? sfh_q : nfh_q;

	always_comb begin
		case (cmd.rd_sel)
			psl_pkg::RD_HEAD: rd_addr = psl_pkg::HEAD_SLOT;
			psl_pkg::RD_LINK: rd_addr = rd_link;
			psl_pkg::RD_FREE: rd_addr = fh_sel;
			psl_pkg::RD_CUR:  rd_addr = item_q.current_slot;
			psl_pkg::RD_TGT:  rd_addr = item_q.target_slot;
			psl_pkg::RD_P:    rd_addr = p_q;
			psl_pkg::RD_Q:    rd_addr = q_q;
			default:          rd_addr = psl_pkg::HEAD_SLOT;
		endcase
	end

	// Release target: the slot pushed back on its own free list
	assign rel_en   = (cmd.wr_op == psl_pkg::WR_REL_TGT) || (cmd.wr_op == psl_pkg::WR_REL_Q);
	assign rel_slot = (cmd.wr_op == psl_pkg::WR_REL_TGT) ? item_q.target_slot : q_q;

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = p_q;
		wr_data = rd_link;
		case (cmd.wr_op)
			psl_pkg::WR_P_LINK: begin
				wr_addr = p_q;
				wr_data = rd_link;
			end
			psl_pkg::WR_CUR_P: begin
				wr_addr = item_q.current_slot;
				wr_data = p_q;
			end
			psl_pkg::WR_REL_TGT, psl_pkg::WR_REL_Q: begin
				wr_addr = rel_slot;
				wr_data = (rel_slot < psl_pkg::SUPER_FIRST) ? nfh_q : sfh_q;
			end
			default: wr_en = 1'b0;
		endcase
	end

	// Memories
	always_ff @(posedge clk) begin
		if (wr_en && wr_addr <= psl_pkg::HEAD_SLOT) begin
			link_mem[wr_addr] <= wr_data;
		end
		if (rd_addr <= psl_pkg::HEAD_SLOT) begin
			link_raw_q <= link_mem[rd_addr];
		end
		rd_addr_q <= rd_addr;
		if (cmd.info_wr && p_q < psl_pkg::HEAD_SLOT) begin
			type_mem[p_q] <= item_q.proc_type;
			hnd_mem[p_q]  <= item_q.handler;
		end
		if (rd_addr < psl_pkg::HEAD_SLOT) begin
			type_rd_q <= type_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_vld_q  <= '0;
			link_rvld_q <= 1'b0;
		end else begin
			if (wr_en && wr_addr <= psl_pkg::HEAD_SLOT) begin
				link_vld_q[wr_addr] <= 1'b1;
			end
			link_rvld_q <= (rd_addr <= psl_pkg::HEAD_SLOT) ? link_vld_q[rd_addr] : 1'b0;
		end
	end

	// Free list heads and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nfh_q       <= '0;
			sfh_q       <= psl_pkg::SUPER_FIRST;
			prot_type_q <= '0;
		end else begin
			if (cfg_we) prot_type_q <= cfg_data;
			if (cmd.fh_pop) begin
				if (sel_super) sfh_q <= rd_link;
				else nfh_q <= rd_link;
			end else if (rel_en) begin
				if (rel_slot < psl_pkg::SUPER_FIRST) nfh_q <= rel_slot;
				else sfh_q <= rel_slot;
			end
		end
	end

	// Item, walk pointers and result
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q       <= req;
			res_slot_q   <= '0;
			res_status_q <= psl_pkg::STAT_OK;
			cnt_q        <= '0;
		end else begin
			if (cmd.stat_set) res_status_q <= cmd.stat_code;
			if (cmd.slot_from_p) res_slot_q <= p_q;
			if (cmd.cnt_inc) cnt_q <= cnt_q + SW'(1);
		end
		case (cmd.p_op)
			psl_pkg::P_HEAD: p_q <= psl_pkg::HEAD_SLOT;
			psl_pkg::P_LINK: p_q <= rd_link;
			psl_pkg::P_FREE: p_q <= fh_sel;
			psl_pkg::P_Q:    p_q <= q_q;
			default:         p_q <= p_q;
		endcase
		if (cmd.q_load) q_q <= rd_link;
		if (cmd.out_load) begin
			rsp_q.slot         <= res_slot_q;
			rsp_q.status       <= res_status_q;
			rsp_q.killed_count <= cnt_q;
		end
	end

	assign rsp = rsp_q;

	assign sts.mode        = item_q.mode;
	assign sts.fh_empty    = (fh_sel >= psl_pkg::HEAD_SLOT);
	assign sts.cur_is_head = (item_q.current_slot == psl_pkg::HEAD_SLOT);
	assign sts.tgt_bad     = (item_q.target_slot >= psl_pkg::HEAD_SLOT);
	assign sts.link_end    = (rd_link >= psl_pkg::HEAD_SLOT);
	assign sts.link_is_cur = (rd_link == item_q.current_slot);
	assign sts.link_is_tgt = (rd_link == item_q.target_slot);
	assign sts.q_spared    = (q_q == item_q.current_slot) || (type_rd_q == prot_type_q);
	assign sts.normal_head = nfh_q;
	assign sts.super_head  = sfh_q;

endmodule

// File: src/process_slot_list_manager_core.sv
// Process slot list manager. Keeps 32 normal and 8 super process slots on
// singly linked lists: one free list per kind and one active list that
// starts at the head sentinel (slot 40). Each accepted item is an allocate,
// a kill or a kill-all and gives exactly one result item. All links live in
// a link memory with one registered read port and one write port, so a list
// is walked one step at a time. An allocate walks the active list up to the
// current slot (no walk when the current slot is the head); a kill walks to
// the target; a kill-all visits every slot in turn and spares or removes it;
// an empty pool or an out-of-range target ends the item without a walk. One
// item is worked on at a time; a finished result waits in the output
// register while the next item is taken. No clearing pass after reset:
// per-entry valid bits make the link memory read its initial free chains
// straight away.
module process_slot_list_manager_core (
	input  logic                       clk,
	input  logic                       arst_n,
	// item in
	input  logic                       req_valid,
	output logic                       req_ready,
	input  psl_pkg::req_t              req,
	// result out
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output psl_pkg::rsp_t              rsp,
	// protected type register write
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [psl_pkg::TYPE_W-1:0] cfg_data
);

	psl_pkg::cmd_t cmd;
	psl_pkg::sts_t sts;

	// the register takes a write in any cycle
	assign cfg_ready = 1'b1;

	// sequencer: walks, links, unlinks and releases, one list step at a time
	psl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// link/type memories, free heads, walk pointers, result register
	psl_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg_we   (cfg_valid),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.rsp      (rsp)
	);

	// free heads always point into their own pool or hold the end mark
	assert property (@(posedge clk) disable iff (!arst_n)
		(sts.normal_head < psl_pkg::SUPER_FIRST || sts.normal_head == psl_pkg::END_MARK) &&
		((sts.super_head >= psl_pkg::SUPER_FIRST && sts.super_head < psl_pkg::HEAD_SLOT) ||
		sts.super_head == psl_pkg::END_MARK))
		else $error("free list head out of its pool");

	// one item in flight: after an accept the input side closes
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("item accepted while another is in flight");

	// an error result carries no slot and no removals
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != psl_pkg::STAT_OK) |-> (rsp.slot == '0 && rsp.killed_count == '0))
		else $error("error result with slot or count set");

	// a new result is only shown when the sequencer loaded it
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(cmd.out_load))
		else $error("result valid without a load");

endmodule
